// ===== rtl/rx_frame_ring_buffer_core_assert.svh =====
// Assertion macros for the receive frame ring buffer.
`ifndef RX_FRAME_RING_BUFFER_CORE_ASSERT_SVH
`define RX_FRAME_RING_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RXFRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RXFRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rxfrb_pkg.sv =====
// Package: types and constants of the receive frame ring buffer.
package rxfrb_pkg;

    localparam int BYTE_DEPTH_DEF = 64;
    localparam int DESC_DEPTH_DEF = 8;
    localparam int MAX_RESULTS    = 64;

    localparam logic [7:0] DEST_POSITION = 8'd2;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [1:0] {
        KIND_RX_BYTE,
        KIND_RX_END,
        KIND_RX_DROP,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic [7:0] poll_address;
        logic       response_seen;
        logic       frame_pending;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DESC,
        S_SEND
    } t_state;

endpackage

// ===== rtl/rxfrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rxfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rxfrb_front.sv =====
// Front end: decodes input requests and queues them for the back end.
module rxfrb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_end,
    input  logic                i_rx_error,
    output logic                o_item_valid,
    output rxfrb_pkg::t_item    o_item,
    input  logic                i_item_pop
);

    import rxfrb_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.data = i_rx_byte;
        if (i_opcode == OP_READ) begin
            w_item.kind = KIND_READ;
        end else if (i_frame_end) begin
            w_item.kind = KIND_RX_END;
        end else if (i_rx_error) begin
            w_item.kind = KIND_RX_DROP;
        end else begin
            w_item.kind = KIND_RX_BYTE;
        end
    end

    assign o_ready      = (r_count != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_item_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        case ({w_push, i_item_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ===== rtl/rxfrb_back.sv =====
// Back end: byte ring, descriptor ring, frame tracking and read-out sequencer.
module rxfrb_back #(
    parameter int BYTE_DEPTH = rxfrb_pkg::BYTE_DEPTH_DEF,
    parameter int DESC_DEPTH = rxfrb_pkg::DESC_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_cfg_match,
    input  logic                i_item_valid,
    input  rxfrb_pkg::t_item    i_item,
    output logic                o_item_pop,
    output logic                o_res_valid,
    output rxfrb_pkg::t_result  o_res,
    input  logic                i_res_ready
);

    import rxfrb_pkg::*;

    localparam int BAW    = $clog2(BYTE_DEPTH);
    localparam int DAW    = $clog2(DESC_DEPTH);
    localparam int DW     = BAW + 8;
    localparam int RD_CAP = (BYTE_DEPTH < MAX_RESULTS) ? BYTE_DEPTH : MAX_RESULTS;
    localparam int LW     = $clog2(RD_CAP + 1);

    t_state         r_state, n_state;
    logic [BAW-1:0] r_wr_idx, n_wr_idx;
    logic [BAW-1:0] r_open_start, n_open_start;
    logic [DAW-1:0] r_head, n_head;
    logic [DAW-1:0] r_tail, n_tail;
    logic [7:0]     r_count, n_count;
    logic [7:0]     r_prev, n_prev;
    logic [7:0]     r_dest, n_dest;
    logic [7:0]     r_poll, n_poll;
    logic [BAW-1:0] r_rd_addr, n_rd_addr;
    logic [LW-1:0]  r_rem, n_rem;
    logic           r_out_valid;
    t_result        r_out;

    logic           w_free;
    logic           w_emit;
    t_result        w_res;
    logic [BAW-1:0] w_wr_inc;
    logic [BAW-1:0] w_rd_inc;
    logic [DAW-1:0] w_head_inc;
    logic [DAW-1:0] w_tail_inc;

    logic           w_ring_we;
    logic [7:0]     w_ring_wdata;
    logic           w_ring_re;
    logic [BAW-1:0] w_ring_raddr;
    logic [7:0]     w_ring_rdata;
    logic           w_desc_we;
    logic           w_desc_re;
    logic [DW-1:0]  w_desc_rdata;
    logic [BAW-1:0] w_desc_start;
    logic [7:0]     w_desc_len;
    logic [LW-1:0]  w_len_cap;
    logic [BAW-1:0] w_start_inc;

    assign w_free      = !r_out_valid || i_res_ready;
    assign w_wr_inc    = (r_wr_idx == BAW'(BYTE_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    assign w_rd_inc    = (r_rd_addr == BAW'(BYTE_DEPTH - 1)) ? '0 : r_rd_addr + 1'b1;
    assign w_head_inc  = (r_head == DAW'(DESC_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_inc  = (r_tail == DAW'(DESC_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_desc_start = w_desc_rdata[DW-1:8];
    assign w_desc_len   = w_desc_rdata[7:0];
    assign w_len_cap    = (w_desc_len > 8'(RD_CAP)) ? LW'(RD_CAP) : LW'(w_desc_len);
    assign w_start_inc  = (w_desc_start == BAW'(BYTE_DEPTH - 1)) ? '0 : w_desc_start + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_wr_idx     = r_wr_idx;
        n_open_start = r_open_start;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_prev       = r_prev;
        n_dest       = r_dest;
        n_poll       = r_poll;
        n_rd_addr    = r_rd_addr;
        n_rem        = r_rem;
        o_item_pop   = 1'b0;
        w_ring_we    = 1'b0;
        w_ring_wdata = i_item.data;
        w_ring_re    = 1'b0;
        w_ring_raddr = r_rd_addr;
        w_desc_we    = 1'b0;
        w_desc_re    = 1'b0;
        w_emit       = 1'b0;

        w_res.out_byte      = 8'd0;
        w_res.byte_valid    = 1'b0;
        w_res.last_of_run   = 1'b1;
        w_res.poll_address  = r_poll;
        w_res.response_seen = 1'b0;
        w_res.frame_pending = (r_head != r_tail);

        case (r_state)
            S_IDLE: begin
                if (i_item_valid && w_free) begin
                    o_item_pop = 1'b1;
                    case (i_item.kind)
                        KIND_READ: begin
                            if (r_head == r_tail) begin
                                w_emit = 1'b1;
                            end else begin
                                w_desc_re = 1'b1;
                                n_state   = S_DESC;
                            end
                        end
                        KIND_RX_END: begin
                            w_ring_we    = 1'b1;
                            w_ring_wdata = 8'd0;
                            w_desc_we    = 1'b1;
                            n_wr_idx     = w_wr_inc;
                            n_open_start = w_wr_inc;
                            n_head       = w_head_inc;
                            n_poll       = (r_count == 8'd1) ? r_prev : 8'd0;
                            n_count      = 8'd0;
                            n_dest       = 8'd0;
                            w_emit       = 1'b1;
                            w_res.poll_address  = n_poll;
                            w_res.response_seen = (r_count > 8'd1) && (r_dest == i_cfg_match);
                            w_res.frame_pending = (w_head_inc != r_tail);
                        end
                        KIND_RX_BYTE: begin
                            w_ring_we = 1'b1;
                            n_wr_idx  = w_wr_inc;
                            n_prev    = i_item.data;
                            n_count   = r_count + 8'd1;
                            if (n_count == DEST_POSITION) begin
                                n_dest = i_item.data;
                            end
                            w_emit = 1'b1;
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_DESC: begin
                if (w_free) begin
                    n_tail = w_tail_inc;
                    if (w_len_cap == '0) begin
                        w_emit  = 1'b1;
                        w_res.frame_pending = (r_head != w_tail_inc);
                        n_state = S_IDLE;
                    end else begin
                        w_ring_re    = 1'b1;
                        w_ring_raddr = w_desc_start;
                        n_rd_addr    = w_start_inc;
                        n_rem        = w_len_cap;
                        n_state      = S_SEND;
                    end
                end
            end
            S_SEND: begin
                if (w_free) begin
                    w_emit            = 1'b1;
                    w_res.out_byte    = w_ring_rdata;
                    w_res.byte_valid  = 1'b1;
                    w_res.last_of_run = (r_rem == LW'(1));
                    n_rem             = r_rem - 1'b1;
                    if (r_rem == LW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        w_ring_re = 1'b1;
                        n_rd_addr = w_rd_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wr_idx     <= '0;
            r_open_start <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= 8'd0;
            r_prev       <= 8'd0;
            r_dest       <= 8'd0;
            r_poll       <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wr_idx     <= n_wr_idx;
            r_open_start <= n_open_start;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_prev       <= n_prev;
            r_dest       <= n_dest;
            r_poll       <= n_poll;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_rem     <= n_rem;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    rxfrb_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (r_wr_idx),
        .i_wdata (w_ring_wdata),
        .i_re    (w_ring_re),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    // descriptor entry: {start, length}
    rxfrb_ram #(
        .WIDTH (DW),
        .DEPTH (DESC_DEPTH)
    ) u_desc_ring (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (r_head),
        .i_wdata ({r_open_start, r_count + 8'd1}),
        .i_re    (w_desc_re),
        .i_raddr (r_tail),
        .o_rdata (w_desc_rdata)
    );

endmodule

// ===== rtl/rx_frame_ring_buffer_core.sv =====
// Top level: receive frame ring buffer with frame descriptors.
//
// Input stream s_axis carries one request per beat: receive a bus byte, mark
// frame end or byte error, or read out the oldest stored frame.
// Output stream m_axis returns one result per receive request and one result
// per byte for a read (one invalid result for an empty ring or empty frame).
// i_cfg_we/i_cfg_wdata write the client match address; write only when idle.
// Requests go through a 2-deep queue, so s_axis_tready drops only when the
// queue is full. Receive requests: the request is registered in the queue,
// then its result in the output register; one request per cycle sustained
// while m_axis_tready stays high. Read requests: a descriptor RAM read, a
// first byte RAM read, then one byte per cycle while m_axis_tready stays
// high. A stalled m_axis holds its result and the back end waits; the queue
// keeps taking requests until full. Synchronous reset empties both rings and
// the queue; stored bytes are not cleared.
module rx_frame_ring_buffer_core #(
    parameter int BYTE_DEPTH = rxfrb_pkg::BYTE_DEPTH_DEF,
    parameter int DESC_DEPTH = rxfrb_pkg::DESC_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // frame_end
    input  logic [1:0]  s_axis_tuser,   // opcode, rx_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, poll_address
    output logic        m_axis_tlast,   // last_of_run
    output logic [2:0]  m_axis_tuser    // byte_valid, response_seen, frame_pending
);

    import rxfrb_pkg::*;

    logic [7:0] r_cfg_match;
    logic       w_item_valid;
    t_item      w_item;
    logic       w_item_pop;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_match <= 8'd0;
        end else if (i_cfg_we) begin
            r_cfg_match <= i_cfg_wdata;
        end
    end

    rxfrb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser[0]),
        .i_rx_byte    (s_axis_tdata),
        .i_frame_end  (s_axis_tlast),
        .i_rx_error   (s_axis_tuser[1]),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    rxfrb_back #(
        .BYTE_DEPTH (BYTE_DEPTH),
        .DESC_DEPTH (DESC_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_match  (r_cfg_match),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_res_valid  (m_axis_tvalid),
        .o_res        (w_res),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {w_res.poll_address, w_res.out_byte};
    assign m_axis_tlast = w_res.last_of_run;
    assign m_axis_tuser = {w_res.frame_pending, w_res.response_seen, w_res.byte_valid};

endmodule

// ===== rtl/rxfrb_checker.sv =====
// Port-level checks of the receive frame ring buffer, bound to the top level.
`include "rx_frame_ring_buffer_core_assert.svh"

module rxfrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);

    // result without a frame byte is a zero byte and ends its run
    `RXFRB_ASSERT_NOW(a_nobyte_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[7:0] == 8'd0), "invalid byte result not last or not zero")

    // response only on a frame-end result of a multi-byte frame: no poll address
    `RXFRB_ASSERT_NOW(a_resp_form, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0] && (m_axis_tdata[15:8] == 8'd0), "response result malformed")

    // a byte of a read run is never flagged as a response
    `RXFRB_ASSERT_NOW(a_run_nopoll, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1], "read byte flagged as response")

    // stalled result holds
    `RXFRB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind rx_frame_ring_buffer_core rxfrb_checker u_rxfrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/rx_frame_ring_buffer_checker.sv =====
// Checker: watches both streams of the frame ring buffer, predicts results and compares them.
module rx_frame_ring_buffer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // frame_end
    input  logic [1:0]  s_axis_tuser,   // opcode, rx_error
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // out_byte, poll_address
    input  logic        m_axis_tlast,   // last_of_run
    input  logic [2:0]  m_axis_tuser,   // byte_valid, response_seen, frame_pending
    output int          o_err_count,
    output int          o_outstanding
);

    import rxfrb_pkg::*;

    localparam int BD = BYTE_DEPTH_DEF;
    localparam int DD = DESC_DEPTH_DEF;
    localparam int AW = $clog2(BD);
    localparam int SW = $clog2(DD);

    logic [7:0]    byte_mem [BD];
    logic [AW-1:0] wr_ptr;
    logic [AW-1:0] frm_start [DD];
    logic [7:0]    frm_len [DD];
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
    logic [7:0]    byte_cnt;
    logic [7:0]    dst_cnt;
    logic [7:0]    last_byte;
    logic [7:0]    dst_byte;
    logic [7:0]    poll_q;
    logic [7:0]    match_addr;

    t_result pending_results [$];
    int      err_total = 0;

    task automatic push_result(input logic [7:0] b, input logic vld, input logic lst,
                               input logic resp);
        t_result r;
        r.out_byte      = b;
        r.byte_valid    = vld;
        r.last_of_run   = lst;
        r.poll_address  = poll_q;
        r.response_seen = resp;
        r.frame_pending = (head != tail);
        pending_results.push_back(r);
    endtask

    task automatic ring_request(input logic op, input logic [7:0] data, input logic fend,
                                input logic err);
        logic          resp;
        int            len;
        logic [AW-1:0] start;
        logic [7:0]    snap [MAX_RESULTS];
        resp = 1'b0;
        if (op == OP_RECEIVE) begin
            if (fend) begin
                byte_mem[wr_ptr] = 8'h00;
                frm_len[head]    = byte_cnt + 8'd1;
                wr_ptr           = wr_ptr + 1'b1;
                poll_q           = (byte_cnt == 8'd1) ? last_byte : 8'h00;
                resp             = (byte_cnt > 8'd1) && (dst_byte == match_addr);
                head             = head + 1'b1;
                frm_start[head]  = wr_ptr;
                frm_len[head]    = 8'd0;
                byte_cnt         = 8'd0;
                dst_cnt          = 8'd0;
                dst_byte         = 8'd0;
            end else if (!err) begin
                byte_mem[wr_ptr] = data;
                wr_ptr           = wr_ptr + 1'b1;
                last_byte        = data;
                byte_cnt         = byte_cnt + 8'd1;
                dst_cnt          = dst_cnt + 8'd1;
                if (dst_cnt == DEST_POSITION) dst_byte = data;
            end
            push_result(8'h00, 1'b0, 1'b1, resp);
        end else if (head == tail) begin
            push_result(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
            len   = int'(frm_len[tail]);
            start = frm_start[tail];
            if (len > BD) len = BD;
            if (len > MAX_RESULTS) len = MAX_RESULTS;
            for (int k = 0; k < len; k++) snap[k] = byte_mem[start + AW'(k)];
            frm_len[tail] = 8'd0;
            tail          = tail + 1'b1;
            if (len == 0) begin
                push_result(8'h00, 1'b0, 1'b1, 1'b0);
            end else begin
                for (int k = 0; k < len; k++) push_result(snap[k], 1'b1, k == len - 1, 1'b0);
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            wr_ptr     = '0;
            head       = '0;
            tail       = '0;
            byte_cnt   = 8'd0;
            dst_cnt    = 8'd0;
            last_byte  = 8'd0;
            dst_byte   = 8'd0;
            poll_q     = 8'd0;
            match_addr = 8'd0;
            for (int k = 0; k < DD; k++) begin
                frm_start[k] = '0;
                frm_len[k]   = 8'd0;
            end
            pending_results.delete();
        end else begin
            if (i_cfg_we) match_addr = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                ring_request(s_axis_tuser[0], s_axis_tdata, s_axis_tlast, s_axis_tuser[1]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request waiting: tdata 0x%0h", m_axis_tdata);
                    err_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
                    check_field("byte_valid", want.byte_valid, m_axis_tuser[0]);
                    check_field("last_of_run", want.last_of_run, m_axis_tlast);
                    check_field("poll_address", want.poll_address, m_axis_tdata[15:8]);
                    check_field("response_seen", want.response_seen, m_axis_tuser[1]);
                    check_field("frame_pending", want.frame_pending, m_axis_tuser[2]);
                end
            end
        end
        o_outstanding <= pending_results.size();
        o_err_count   <= err_total;
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives requests and address writes into the frame ring buffer, gives the verdict.
module tb_top;
    import rxfrb_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic [1:0]  s_axis_tuser  = 2'b00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    int          err_count;
    int          outstanding;
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    int          sent_count   = 0;
    logic [7:0]  cfg_val      = 8'h00;

    always #5 i_clk = ~i_clk;

    rx_frame_ring_buffer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    rx_frame_ring_buffer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_err_count   (err_count),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic send_request(input logic op, input logic [7:0] data, input logic fend,
                                input logic err);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= fend;
        s_axis_tuser  <= {err, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_read();
        send_request(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // n good bytes, stray error bytes mixed in; hit puts our address in the second byte
    task automatic send_frame(input int n, input logic hit);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 8) send_request(OP_RECEIVE, 8'($urandom), 1'b0, 1'b1);
            b = 8'($urandom);
            if (k == 1 && hit) b = cfg_val;
            send_request(OP_RECEIVE, b, 1'b0, 1'b0);
        end
        send_request(OP_RECEIVE, 8'($urandom), 1'b1, 1'($urandom));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_match_address(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cfg_val      = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int pick;
        int read_pct;
        int goal;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        write_match_address(8'hFF);
        send_request(OP_READ, 8'hFF, 1'b1, 1'b1);
        send_request(OP_RECEIVE, 8'hFF, 1'b0, 1'b1);
        send_request(OP_RECEIVE, 8'h00, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'hFF, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'h00, 1'b1, 1'b0);
        send_request(OP_RECEIVE, 8'hA5, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'h5A, 1'b1, 1'b1);
        send_request(OP_RECEIVE, 8'h00, 1'b1, 1'b0);
        send_request(OP_READ, 8'h00, 1'b0, 1'b0);
        send_request(OP_READ, 8'h00, 1'b0, 1'b0);
        send_request(OP_READ, 8'h00, 1'b0, 1'b0);
        send_request(OP_READ, 8'h00, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'h12, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'h34, 1'b0, 1'b1);
        send_request(OP_RECEIVE, 8'hFF, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'h80, 1'b0, 1'b0);
        send_request(OP_RECEIVE, 8'hFF, 1'b1, 1'b1);
        send_request(OP_READ, 8'hFF, 1'b1, 1'b0);
        send_request(OP_READ, 8'h00, 1'b0, 1'b1);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 7;
                    dst_idle_pct = 56;
                    write_match_address(8'h00);
                end
                1: begin
                    src_idle_pct = 56;
                    dst_idle_pct = 7;
                    write_match_address(8'($urandom));
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                    write_match_address(8'($urandom));
                end
            endcase
            goal     = sent_count + 20;
            read_pct = $urandom_range(15, 60);
            while (sent_count < goal) begin
                if ($urandom_range(19) == 0) read_pct = $urandom_range(10, 70);
                pick = $urandom_range(99);
                if (pick < 10) begin
                    send_request(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                end else if (pick < 10 + read_pct) begin
                    send_read();
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 70) send_frame($urandom_range(0, 4), 1'($urandom));
                    else if (pick < 95) send_frame($urandom_range(5, 20), 1'($urandom));
                    else send_frame($urandom_range(60, 70), 1'($urandom));
                end
                if ($urandom_range(49) == 0) wait_for_results();
            end
            // counter wrap: 255 bytes closes an empty frame
            if (phase == 0) begin
                send_frame(255, 1'b1);
                repeat (DESC_DEPTH_DEF + 1) send_read();
            end
            wait_for_results();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && outstanding == 0) begin
            $display("PASS rx_frame_ring_buffer_core");
        end else begin
            $display("FAIL rx_frame_ring_buffer_core");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL rx_frame_ring_buffer_core");
        $finish;
    end

endmodule
